>>> rtl/core/b64se_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64se_pkg
// Types, constants and the character table shared by the Base64 encoder.
// ----------------------------------------------------------------------------
package b64se_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned TripleW = 3 * ByteW;
  localparam int unsigned QDepth  = 2;

  localparam logic [ByteW-1:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [TripleW-1:0] triple;
    logic [1:0]         pads;
    logic               last;
  } group_t;

  function automatic logic [ByteW-1:0] b64_char(input logic [SextetW-1:0] s);
    logic [ByteW-1:0] c;
    c = '0;
    if (s < 6'd26) begin
      c = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      c = 8'h61 + {2'b00, s - 6'd26};
    end else if (s < 6'd62) begin
      c = 8'h30 + {2'b00, s - 6'd52};
    end else if (s == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/b64se_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64se_front
// Collects message bytes into groups of three and pushes closed groups.
// ----------------------------------------------------------------------------
module b64se_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [b64se_pkg::ByteW-1:0] byte_i,
  input  wire logic                       last_i,
  output      logic                       push_o,
  output      b64se_pkg::group_t          group_o
);
  import b64se_pkg::*;

  logic [2*ByteW-1:0] pend_d, pend_q;
  logic [1:0]         cnt_d, cnt_q;
  logic [1:0]         held;
  logic               closing;

  always_comb begin
    held    = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
    closing = (held == 2'd2) || last_i;
    group_o.last = last_i;
    case (held)
      2'd0: begin
        group_o.triple = {byte_i, 16'h0000};
        group_o.pads   = 2'd2;
      end
      2'd1: begin
        group_o.triple = {pend_q[ByteW-1:0], byte_i, 8'h00};
        group_o.pads   = 2'd1;
      end
      default: begin
        group_o.triple = {pend_q, byte_i};
        group_o.pads   = 2'd0;
      end
    endcase
    push_o = accept_i && closing;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (accept_i) begin
      if (closing) begin
        pend_d = '0;
        cnt_d  = 2'd0;
      end else begin
        pend_d = {pend_q[ByteW-1:0], byte_i};
        cnt_d  = held + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= 2'd0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/b64se_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64se_queue
// Two-entry queue of closed groups between the front and back parts.
// ----------------------------------------------------------------------------
module b64se_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire b64se_pkg::group_t group_i,
  input  wire logic              pop_i,
  output      logic              full_o,
  output      logic              empty_o,
  output      b64se_pkg::group_t head_o
);
  import b64se_pkg::*;

  group_t mem_q [QDepth];
  logic   wr_d, wr_q, rd_d, rd_q;
  logic [1:0] cnt_d, cnt_q;

  always_comb begin
    full_o  = (cnt_q == 2'(QDepth));
    empty_o = (cnt_q == 2'd0);
    head_o  = mem_q[rd_q];
    wr_d    = push_i ? ~wr_q : wr_q;
    rd_d    = pop_i ? ~rd_q : rd_q;
    cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/b64se_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64se_back
// Turns the queued group into four characters, one per cycle unless
// the output stalls, through an output register.
// ----------------------------------------------------------------------------
module b64se_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        empty_i,
  input  wire b64se_pkg::group_t           head_i,
  output      logic                        pop_o,
  output      logic                        valid_o,
  input  wire logic                        ready_i,
  output      logic [b64se_pkg::ByteW-1:0] char_o,
  output      logic                        last_o
);
  import b64se_pkg::*;

  logic [1:0]         k_d, k_q;
  logic               vld_d, vld_q;
  logic [ByteW-1:0]   chr_d, chr_q;
  logic               lst_d, lst_q;
  logic [SextetW-1:0] sextet;
  logic               load;
  logic               is_pad;

  always_comb begin
    case (k_q)
      2'd0:    sextet = head_i.triple[23:18];
      2'd1:    sextet = head_i.triple[17:12];
      2'd2:    sextet = head_i.triple[11:6];
      default: sextet = head_i.triple[5:0];
    endcase
    is_pad = ((head_i.pads == 2'd2) && (k_q >= 2'd2)) ||
             ((head_i.pads == 2'd1) && (k_q == 2'd3));
    load  = (!vld_q || ready_i) && !empty_i;
    pop_o = load && (k_q == 2'd3);
    k_d   = load ? k_q + 2'd1 : k_q;
    vld_d = load ? 1'b1 : (vld_q && !ready_i);
    chr_d = chr_q;
    lst_d = lst_q;
    if (load) begin
      chr_d = is_pad ? PadChar : b64_char(sextet);
      lst_d = head_i.last && (k_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= 2'd0;
      vld_q <= 1'b0;
    end else begin
      k_q   <= k_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chr_q <= chr_d;
    lst_q <= lst_d;
  end

  assign valid_o = vld_q;
  assign char_o  = chr_q;
  assign last_o  = lst_q;

endmodule
`default_nettype wire

>>> rtl/core/base64_stream_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Streaming Base64 encoder with the standard alphabet and '=' padding.
// ----------------------------------------------------------------------------
// Channel   Direction  Request
// s_axis    in         one message byte, tlast on the final byte
// m_axis    out        one ASCII character, tlast on the final character
//
// A byte is taken in every cycle in which the two-entry group queue has room.
// Characters leave one per cycle from the output register while the sink is
// ready and a group is queued, so a group of three bytes becomes four
// characters; the output side, not the input, limits the sustained rate.
// Reset clears the pending bytes, the queue and the output valid flag.
// A stall on the output fills the queue, which then stalls the input.
// ----------------------------------------------------------------------------
module base64_stream_encoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output      logic       s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,
  output      logic       m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output      logic [7:0] m_axis_tdata,   // [7:0] out_char
  output      logic       m_axis_tlast
);
  import b64se_pkg::*;

  logic   accept, push, pop, full, empty;
  group_t grp, head;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  b64se_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .push_o  (push),
    .group_o (grp)
  );

  b64se_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .group_i(grp),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .head_o (head)
  );

  b64se_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .head_i (head),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .char_o (m_axis_tdata),
    .last_o (m_axis_tlast)
  );

endmodule
`default_nettype wire
